@@ hw/rtl/vvu_pkg.sv @@
// Types, constants and helpers shared by the vector unit modules.
package vvu_pkg;

   typedef enum logic [2:0] {
      ACT_ADD   = 3'd0,
      ACT_SUB   = 3'd1,
      ACT_SCALE = 3'd2,
      ACT_DOT   = 3'd3,
      ACT_CROSS = 3'd4,
      ACT_MAG   = 3'd5,
      ACT_NORM  = 3'd6,
      ACT_DIST  = 3'd7
   } action_type;

   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 48;
   localparam logic [15:0] EPS_RESET = 16'd1;
   localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] S32_MIN = 32'h8000_0000;

   typedef struct packed {
      action_type  action;
      logic [31:0] rx;
      logic [31:0] ry;
      logic [31:0] rz;
      logic [31:0] rs;
      logic        status;
      logic [2:0]  neg;
      logic [31:0] abs_x;
      logic [31:0] abs_y;
      logic [31:0] abs_z;
   } pkt_type;

   typedef struct packed {
      logic [63:0] rad;
      logic [35:0] rem;
      logic [31:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [47:0] dvd;
      logic [31:0] rem;
   } div_lane_type;

   typedef struct packed {
      div_lane_type lx;
      div_lane_type ly;
      div_lane_type lz;
      logic [31:0]  den;
   } div_type;

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sd2147483647)
         r = S32_MAX;
      else if (v < -64'sd2147483648)
         r = S32_MIN;
      else
         r = v[31:0];
      return r;
   endfunction

   // signed, saturated result from an unsigned quotient magnitude
   function automatic logic [31:0] sign_sat(input logic neg, input logic [47:0] q);
      logic [31:0] r;
      if (neg) begin
         if (q > 48'h0000_8000_0000)
            r = S32_MIN;
         else
            r = ~q[31:0] + 32'd1;
      end else begin
         if (q > 48'h0000_7FFF_FFFF)
            r = S32_MAX;
         else
            r = q[31:0];
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/vec3_vector_unit.sv @@
// Top level of the Q16.16 three-component vector unit.
// Fully pipelined: one transaction is taken every cycle (busy is always low), and
// every action returns its result in order, after passing through three front stages
// (request capture, operand select, six 32x32 multipliers), a chain of 32 square
// root cells and a chain of 48 divider cells, then the output register.
// The result is shown for one cycle with rsp_strobe; the receiver cannot stall.
// Write csr_wdata (epsilon) only while no transaction is in flight.
module vec3_vector_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic signed [31:0] req_a_x,
   input  logic signed [31:0] req_a_y,
   input  logic signed [31:0] req_a_z,
   input  logic signed [31:0] req_b_x,
   input  logic signed [31:0] req_b_y,
   input  logic signed [31:0] req_b_z,
   input  logic signed [31:0] req_scale_factor,
   input  logic               csr_we,
   input  logic [15:0]        csr_wdata,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_res_x,
   output logic signed [31:0] rsp_res_y,
   output logic signed [31:0] rsp_res_z,
   output logic signed [31:0] rsp_res_scalar,
   output logic               rsp_status
);

   localparam int LAT = 3 + vvu_pkg::SQRT_STEPS + vvu_pkg::DIV_STEPS + 1;

   logic [15:0] eps_ff;

   // stage 0: captured request
   logic                v0_ff;
   vvu_pkg::action_type act0_ff;
   logic signed [31:0]  ax0_ff, ay0_ff, az0_ff, bx0_ff, by0_ff, bz0_ff, sf0_ff;

   // stage 1: operands
   logic               v1_ff;
   vvu_pkg::pkt_type   pkt1_ff, pkt1_in;
   logic signed [31:0] opa_ff [6];
   logic signed [31:0] opb_ff [6];
   logic signed [31:0] opa_in [6];
   logic signed [31:0] opb_in [6];

   // stage 2: products
   logic               v2_ff;
   vvu_pkg::pkt_type   pkt2_ff;
   logic signed [63:0] prod_ff [6];

   logic signed [63:0] sum_x, sum_y, sum_z, dif_x, dif_y, dif_z;
   logic signed [31:0] dx, dy, dz;
   logic signed [63:0] fl [6];
   vvu_pkg::pkt_type   pkt3;
   vvu_pkg::sqrt_type  sq3;

   logic              sq_v   [vvu_pkg::SQRT_STEPS + 1];
   vvu_pkg::pkt_type  sq_pkt [vvu_pkg::SQRT_STEPS + 1];
   vvu_pkg::sqrt_type sq_st  [vvu_pkg::SQRT_STEPS + 1];

   logic             dv_v   [vvu_pkg::DIV_STEPS + 1];
   vvu_pkg::pkt_type dv_pkt [vvu_pkg::DIV_STEPS + 1];
   vvu_pkg::div_type dv_st  [vvu_pkg::DIV_STEPS + 1];

   logic [31:0] root;
   vvu_pkg::pkt_type post_pkt, fin_pkt;
   vvu_pkg::div_type fin_st;

   logic        out_v_ff;
   logic [31:0] out_x_ff, out_y_ff, out_z_ff, out_s_ff, out_x_in, out_y_in, out_z_in;
   logic        out_st_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset)
         eps_ff <= vvu_pkg::EPS_RESET;
      else if (csr_we)
         eps_ff <= csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset)
         v0_ff <= 1'b0;
      else
         v0_ff <= start & ~busy;
      act0_ff <= vvu_pkg::action_type'(req_action);
      ax0_ff  <= req_a_x;
      ay0_ff  <= req_a_y;
      az0_ff  <= req_a_z;
      bx0_ff  <= req_b_x;
      by0_ff  <= req_b_y;
      bz0_ff  <= req_b_z;
      sf0_ff  <= req_scale_factor;
   end

   always_comb begin
      sum_x = 64'(ax0_ff) + 64'(bx0_ff);
      sum_y = 64'(ay0_ff) + 64'(by0_ff);
      sum_z = 64'(az0_ff) + 64'(bz0_ff);
      dif_x = 64'(ax0_ff) - 64'(bx0_ff);
      dif_y = 64'(ay0_ff) - 64'(by0_ff);
      dif_z = 64'(az0_ff) - 64'(bz0_ff);
      dx = vvu_pkg::sat32(dif_x);
      dy = vvu_pkg::sat32(dif_y);
      dz = vvu_pkg::sat32(dif_z);

      pkt1_in.action = act0_ff;
      pkt1_in.rx     = '0;
      pkt1_in.ry     = '0;
      pkt1_in.rz     = '0;
      pkt1_in.rs     = '0;
      pkt1_in.status = 1'b0;
      pkt1_in.neg    = {az0_ff[31], ay0_ff[31], ax0_ff[31]};
      pkt1_in.abs_x  = ax0_ff[31] ? (~ax0_ff + 32'd1) : ax0_ff;
      pkt1_in.abs_y  = ay0_ff[31] ? (~ay0_ff + 32'd1) : ay0_ff;
      pkt1_in.abs_z  = az0_ff[31] ? (~az0_ff + 32'd1) : az0_ff;
      for (int i = 0; i < 6; i++) begin
         opa_in[i] = '0;
         opb_in[i] = '0;
      end

      unique case (act0_ff)
         vvu_pkg::ACT_ADD: begin
            pkt1_in.rx = vvu_pkg::sat32(sum_x);
            pkt1_in.ry = vvu_pkg::sat32(sum_y);
            pkt1_in.rz = vvu_pkg::sat32(sum_z);
         end
         vvu_pkg::ACT_SUB: begin
            pkt1_in.rx = dx;
            pkt1_in.ry = dy;
            pkt1_in.rz = dz;
         end
         vvu_pkg::ACT_SCALE: begin
            opa_in[0] = ax0_ff; opb_in[0] = sf0_ff;
            opa_in[1] = ay0_ff; opb_in[1] = sf0_ff;
            opa_in[2] = az0_ff; opb_in[2] = sf0_ff;
         end
         vvu_pkg::ACT_DOT: begin
            opa_in[0] = ax0_ff; opb_in[0] = bx0_ff;
            opa_in[1] = ay0_ff; opb_in[1] = by0_ff;
            opa_in[2] = az0_ff; opb_in[2] = bz0_ff;
         end
         vvu_pkg::ACT_CROSS: begin
            opa_in[0] = ay0_ff; opb_in[0] = bz0_ff;
            opa_in[1] = az0_ff; opb_in[1] = by0_ff;
            opa_in[2] = az0_ff; opb_in[2] = bx0_ff;
            opa_in[3] = ax0_ff; opb_in[3] = bz0_ff;
            opa_in[4] = ax0_ff; opb_in[4] = by0_ff;
            opa_in[5] = ay0_ff; opb_in[5] = bx0_ff;
         end
         vvu_pkg::ACT_MAG, vvu_pkg::ACT_NORM: begin
            opa_in[0] = ax0_ff; opb_in[0] = ax0_ff;
            opa_in[1] = ay0_ff; opb_in[1] = ay0_ff;
            opa_in[2] = az0_ff; opb_in[2] = az0_ff;
         end
         vvu_pkg::ACT_DIST: begin
            opa_in[0] = dx; opb_in[0] = dx;
            opa_in[1] = dy; opb_in[1] = dy;
            opa_in[2] = dz; opb_in[2] = dz;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
      pkt1_ff <= pkt1_in;
      pkt2_ff <= pkt1_ff;
      for (int i = 0; i < 6; i++) begin
         opa_ff[i]  <= opa_in[i];
         opb_ff[i]  <= opb_in[i];
         prod_ff[i] <= opa_ff[i] * opb_ff[i];
      end
   end

   // stage 3: floor products, combine, form the radicand
   always_comb begin
      for (int i = 0; i < 6; i++)
         fl[i] = prod_ff[i] >>> 16;
      pkt3 = pkt2_ff;
      unique case (pkt2_ff.action)
         vvu_pkg::ACT_SCALE: begin
            pkt3.rx = vvu_pkg::sat32(fl[0]);
            pkt3.ry = vvu_pkg::sat32(fl[1]);
            pkt3.rz = vvu_pkg::sat32(fl[2]);
         end
         vvu_pkg::ACT_DOT:
            pkt3.rs = vvu_pkg::sat32(fl[0] + fl[1] + fl[2]);
         vvu_pkg::ACT_CROSS: begin
            pkt3.rx = vvu_pkg::sat32(fl[0] - fl[1]);
            pkt3.ry = vvu_pkg::sat32(fl[2] - fl[3]);
            pkt3.rz = vvu_pkg::sat32(fl[4] - fl[5]);
         end
         default: ;
      endcase
      sq3.rad  = $unsigned(prod_ff[0]) + $unsigned(prod_ff[1]) + $unsigned(prod_ff[2]);
      sq3.rem  = '0;
      sq3.root = '0;
   end

   assign sq_v[0]   = v2_ff;
   assign sq_pkt[0] = pkt3;
   assign sq_st[0]  = sq3;

   for (genvar g = 0; g < vvu_pkg::SQRT_STEPS; g++) begin : g_sqrt
      vvu_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_v[g]),
         .in_pkt    (sq_pkt[g]),
         .in_st     (sq_st[g]),
         .out_valid (sq_v[g+1]),
         .out_pkt   (sq_pkt[g+1]),
         .out_st    (sq_st[g+1])
      );
   end

   always_comb begin
      root     = sq_st[vvu_pkg::SQRT_STEPS].root;
      post_pkt = sq_pkt[vvu_pkg::SQRT_STEPS];
      priority case (post_pkt.action)
         vvu_pkg::ACT_MAG, vvu_pkg::ACT_DIST:
            post_pkt.rs = root[31] ? vvu_pkg::S32_MAX : root;
         vvu_pkg::ACT_NORM:
            post_pkt.status = (root < {16'b0, eps_ff}) || (root == '0);
         default: ;
      endcase
   end

   assign dv_v[0]          = sq_v[vvu_pkg::SQRT_STEPS];
   assign dv_pkt[0]        = post_pkt;
   assign dv_st[0].lx.dvd  = {post_pkt.abs_x, 16'b0};
   assign dv_st[0].ly.dvd  = {post_pkt.abs_y, 16'b0};
   assign dv_st[0].lz.dvd  = {post_pkt.abs_z, 16'b0};
   assign dv_st[0].lx.rem  = '0;
   assign dv_st[0].ly.rem  = '0;
   assign dv_st[0].lz.rem  = '0;
   assign dv_st[0].den     = root;

   for (genvar g = 0; g < vvu_pkg::DIV_STEPS; g++) begin : g_div
      vvu_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_v[g]),
         .in_pkt    (dv_pkt[g]),
         .in_st     (dv_st[g]),
         .out_valid (dv_v[g+1]),
         .out_pkt   (dv_pkt[g+1]),
         .out_st    (dv_st[g+1])
      );
   end

   always_comb begin
      fin_pkt  = dv_pkt[vvu_pkg::DIV_STEPS];
      fin_st   = dv_st[vvu_pkg::DIV_STEPS];
      out_x_in = fin_pkt.rx;
      out_y_in = fin_pkt.ry;
      out_z_in = fin_pkt.rz;
      if (fin_pkt.action == vvu_pkg::ACT_NORM) begin
         if (fin_pkt.status) begin
            out_x_in = '0;
            out_y_in = '0;
            out_z_in = '0;
         end else begin
            out_x_in = vvu_pkg::sign_sat(fin_pkt.neg[0], fin_st.lx.dvd);
            out_y_in = vvu_pkg::sign_sat(fin_pkt.neg[1], fin_st.ly.dvd);
            out_z_in = vvu_pkg::sign_sat(fin_pkt.neg[2], fin_st.lz.dvd);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         out_v_ff <= 1'b0;
      else
         out_v_ff <= dv_v[vvu_pkg::DIV_STEPS];
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      out_z_ff  <= out_z_in;
      out_s_ff  <= fin_pkt.rs;
      out_st_ff <= fin_pkt.status;
   end

   assign rsp_strobe     = out_v_ff;
   assign rsp_res_x      = out_x_ff;
   assign rsp_res_y      = out_y_ff;
   assign rsp_res_z      = out_z_ff;
   assign rsp_res_scalar = out_s_ff;
   assign rsp_status     = out_st_ff;

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("response missing at fixed latency");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("response without request");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status) |->
         (rsp_res_x == '0 && rsp_res_y == '0 && rsp_res_z == '0 && rsp_res_scalar == '0))
      else $error("failed normalize returned nonzero data");

endmodule

@@ hw/rtl/vvu_sqrt_cell.sv @@
// One digit cell of the square root chain: one result bit per cell.
module vvu_sqrt_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  vvu_pkg::pkt_type  in_pkt,
   input  vvu_pkg::sqrt_type in_st,
   output logic              out_valid,
   output vvu_pkg::pkt_type  out_pkt,
   output vvu_pkg::sqrt_type out_st
);

   logic              valid_ff;
   vvu_pkg::pkt_type  pkt_ff;
   vvu_pkg::sqrt_type st_ff, st_in;
   logic [35:0]       rem_n;
   logic [35:0]       trial;
   logic              ge;

   always_comb begin
      rem_n = {in_st.rem[33:0], in_st.rad[63:62]};
      trial = {2'b00, in_st.root, 2'b01};
      ge    = (rem_n >= trial);
      st_in.rad  = {in_st.rad[61:0], 2'b00};
      st_in.rem  = ge ? (rem_n - trial) : rem_n;
      st_in.root = {in_st.root[30:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= in_valid;
      pkt_ff <= in_pkt;
      st_ff  <= st_in;
   end

   assign out_valid = valid_ff;
   assign out_pkt   = pkt_ff;
   assign out_st    = st_ff;

endmodule

@@ hw/rtl/vvu_div_cell.sv @@
// One step cell of the divider chain: one quotient bit per lane per cell.
module vvu_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  vvu_pkg::pkt_type in_pkt,
   input  vvu_pkg::div_type in_st,
   output logic             out_valid,
   output vvu_pkg::pkt_type out_pkt,
   output vvu_pkg::div_type out_st
);

   logic             valid_ff;
   vvu_pkg::pkt_type pkt_ff;
   vvu_pkg::div_type st_ff, st_in;

   function automatic vvu_pkg::div_lane_type lane_step(input vvu_pkg::div_lane_type l,
                                                       input logic [31:0] den);
      vvu_pkg::div_lane_type r;
      logic [32:0] rem_n;
      logic        ge;
      rem_n = {l.rem, l.dvd[47]};
      ge    = (rem_n >= {1'b0, den});
      r.rem = ge ? 32'(rem_n - {1'b0, den}) : rem_n[31:0];
      r.dvd = {l.dvd[46:0], ge};
      return r;
   endfunction

   always_comb begin
      st_in.lx  = lane_step(in_st.lx, in_st.den);
      st_in.ly  = lane_step(in_st.ly, in_st.den);
      st_in.lz  = lane_step(in_st.lz, in_st.den);
      st_in.den = in_st.den;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= in_valid;
      pkt_ff <= in_pkt;
      st_ff  <= st_in;
   end

   assign out_valid = valid_ff;
   assign out_pkt   = pkt_ff;
   assign out_st    = st_ff;

endmodule

@@ tb/tb_vec3_vector_unit.sv @@
// Self-checking testbench for the Q16.16 three-component vector unit.
`timescale 1ns / 100ps

module tb_vec3_vector_unit;

   localparam int LATENCY = 84;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      vvu_pkg::action_type action;
      logic signed [31:0] ax, ay, az, bx, by, bz, sf;
   } vec_op_type;

   typedef struct {
      logic signed [31:0] rx, ry, rz, rs;
      logic status;
   } vec_res_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_action = '0;
   logic signed [31:0] req_a_x = '0, req_a_y = '0, req_a_z = '0;
   logic signed [31:0] req_b_x = '0, req_b_y = '0, req_b_z = '0;
   logic signed [31:0] req_scale_factor = '0;
   logic csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;
   logic rsp_strobe;
   logic signed [31:0] rsp_res_x, rsp_res_y, rsp_res_z, rsp_res_scalar;
   logic rsp_status;

   vec3_vector_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action),
      .req_a_x(req_a_x), .req_a_y(req_a_y), .req_a_z(req_a_z),
      .req_b_x(req_b_x), .req_b_y(req_b_y), .req_b_z(req_b_z),
      .req_scale_factor(req_scale_factor),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_strobe(rsp_strobe),
      .rsp_res_x(rsp_res_x), .rsp_res_y(rsp_res_y), .rsp_res_z(rsp_res_z),
      .rsp_res_scalar(rsp_res_scalar), .rsp_status(rsp_status)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   vec_op_type  pending_ops[$];
   vec_res_type expected_results[$];
   logic [15:0] epsilon = vvu_pkg::EPS_RESET;
   int errors = 0;
   int gap = 0;
   int idle_cycles = 0;
   bit running = 1'b0;

   // Q16.16 helpers, in 64-bit signed and 128-bit unsigned math
   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return 32'(v);
   endfunction

   function automatic longint qmul(input longint x, input longint y);
      longint p;
      p = x * y;
      return p >>> 16;
   endfunction

   function automatic longint floor_sqrt(input logic [127:0] n);
      logic [127:0] r, b;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         b = r | (128'd1 << i);
         if (b * b <= n) r = b;
      end
      return longint'(r);
   endfunction

   function automatic longint vec_length(input longint x, input longint y, input longint z);
      logic [127:0] s;
      s = 128'(x * x) + 128'(y * y) + 128'(z * z);
      return floor_sqrt(s);
   endfunction

   function automatic vec_res_type compute_vector_op(input vec_op_type op);
      vec_res_type r;
      longint ax, ay, az, bx, by, bz, sf, m;
      ax = longint'(op.ax); ay = longint'(op.ay); az = longint'(op.az);
      bx = longint'(op.bx); by = longint'(op.by); bz = longint'(op.bz);
      sf = longint'(op.sf);
      r = '{0, 0, 0, 0, 1'b0};
      case (op.action)
         vvu_pkg::ACT_ADD: begin
            r.rx = clamp32(ax + bx); r.ry = clamp32(ay + by); r.rz = clamp32(az + bz);
         end
         vvu_pkg::ACT_SUB: begin
            r.rx = clamp32(ax - bx); r.ry = clamp32(ay - by); r.rz = clamp32(az - bz);
         end
         vvu_pkg::ACT_SCALE: begin
            r.rx = clamp32(qmul(ax, sf)); r.ry = clamp32(qmul(ay, sf));
            r.rz = clamp32(qmul(az, sf));
         end
         vvu_pkg::ACT_DOT: r.rs = clamp32(qmul(ax, bx) + qmul(ay, by) + qmul(az, bz));
         vvu_pkg::ACT_CROSS: begin
            r.rx = clamp32(qmul(ay, bz) - qmul(az, by));
            r.ry = clamp32(qmul(az, bx) - qmul(ax, bz));
            r.rz = clamp32(qmul(ax, by) - qmul(ay, bx));
         end
         vvu_pkg::ACT_MAG: r.rs = clamp32(vec_length(ax, ay, az));
         vvu_pkg::ACT_NORM: begin
            m = vec_length(ax, ay, az);
            if (m < longint'(epsilon) || m == 0) begin
               r.status = 1'b1;
            end else begin
               r.rx = clamp32((ax * 65536) / m);
               r.ry = clamp32((ay * 65536) / m);
               r.rz = clamp32((az * 65536) / m);
            end
         end
         default: begin
            r.rs = clamp32(vec_length(longint'(clamp32(ax - bx)),
                                      longint'(clamp32(ay - by)),
                                      longint'(clamp32(az - bz))));
         end
      endcase
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset || !running) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         expected_results.push_back(compute_vector_op(pending_ops.pop_front()));
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
         if (gap == 0 && pending_ops.size() > 0) begin
            req_action <= pending_ops[0].action;
            req_a_x <= pending_ops[0].ax; req_a_y <= pending_ops[0].ay;
            req_a_z <= pending_ops[0].az; req_b_x <= pending_ops[0].bx;
            req_b_y <= pending_ops[0].by; req_b_z <= pending_ops[0].bz;
            req_scale_factor <= pending_ops[0].sf;
         end else begin
            start <= 1'b0;
         end
      end else if (!start && pending_ops.size() > 0) begin
         if (gap > 0) begin
            gap--;
         end else begin
            start <= 1'b1;
            req_action <= pending_ops[0].action;
            req_a_x <= pending_ops[0].ax; req_a_y <= pending_ops[0].ay;
            req_a_z <= pending_ops[0].az; req_b_x <= pending_ops[0].bx;
            req_b_y <= pending_ops[0].by; req_b_z <= pending_ops[0].bz;
            req_scale_factor <= pending_ops[0].sf;
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      vec_res_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result x=%h y=%h z=%h s=%h st=%b", $time,
                     rsp_res_x, rsp_res_y, rsp_res_z, rsp_res_scalar, rsp_status);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_res_x !== want.rx || rsp_res_y !== want.ry || rsp_res_z !== want.rz ||
                rsp_res_scalar !== want.rs || rsp_status !== want.status) begin
               $display("%0t: mismatch expected x=%h y=%h z=%h s=%h st=%b", $time,
                        want.rx, want.ry, want.rz, want.rs, want.status);
               $display("%0t:          actual   x=%h y=%h z=%h s=%h st=%b", $time,
                        rsp_res_x, rsp_res_y, rsp_res_z, rsp_res_scalar, rsp_status);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy) ||
          (pending_ops.size() == 0 && expected_results.size() == 0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("vec3_vector_unit test failed");
         $finish;
      end
   end

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return 32'(signed'($urandom_range(0, 8)) - 4);
         3: return 32'(signed'($urandom_range(0, 2 << 16)) - (1 << 16));
         4: return 32'(signed'($urandom_range(0, 512 << 16)) - (256 << 16));
         default: return $urandom;
      endcase
   endfunction

   function automatic vec_op_type random_op();
      vec_op_type op;
      op.action = vvu_pkg::action_type'($urandom_range(0, 7));
      op.ax = pick_value(); op.ay = pick_value(); op.az = pick_value();
      op.bx = pick_value(); op.by = pick_value(); op.bz = pick_value();
      op.sf = pick_value();
      return op;
   endfunction

   task automatic add_op(input vvu_pkg::action_type act, input logic signed [31:0] ax, ay, az,
                         bx, by, bz, sf);
      pending_ops.push_back('{act, ax, ay, az, bx, by, bz, sf});
   endtask

   task automatic drain();
      while (pending_ops.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_epsilon(input logic [15:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      epsilon = v;
   endtask

   localparam logic signed [31:0] MX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MN = 32'sh8000_0000;
   localparam logic signed [31:0] ONE = 32'sh0001_0000;

   initial begin
      logic [15:0] eps_list[5];
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      running = 1'b1;

      // directed: extremes, each action, saturation, zero-length normalize
      add_op(vvu_pkg::ACT_ADD, MX, MN, ONE, MX, MN, -ONE, 0);
      add_op(vvu_pkg::ACT_SUB, MX, MN, 0, MN, MX, 0, 0);
      add_op(vvu_pkg::ACT_SCALE, MX, MN, -ONE, 0, 0, 0, MN);
      add_op(vvu_pkg::ACT_SCALE, ONE, -ONE, 3, 0, 0, 0, -1);
      add_op(vvu_pkg::ACT_DOT, MX, MX, MX, MX, MX, MX, 0);
      add_op(vvu_pkg::ACT_DOT, MN, MN, MN, MX, MX, MX, 0);
      add_op(vvu_pkg::ACT_DOT, -1, 1, -1, 1, 1, 1, 0);
      add_op(vvu_pkg::ACT_CROSS, MN, MX, MN, MX, MN, MX, 0);
      add_op(vvu_pkg::ACT_CROSS, ONE, 0, 0, 0, ONE, 0, 0);
      add_op(vvu_pkg::ACT_MAG, MN, MN, MN, 0, 0, 0, 0);
      add_op(vvu_pkg::ACT_MAG, 0, 0, 0, 0, 0, 0, 0);
      add_op(vvu_pkg::ACT_MAG, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0);
      add_op(vvu_pkg::ACT_NORM, 0, 0, 0, 0, 0, 0, 0);
      add_op(vvu_pkg::ACT_NORM, 1, 0, 0, 0, 0, 0, 0);
      add_op(vvu_pkg::ACT_NORM, MN, MN, MN, 0, 0, 0, 0);
      add_op(vvu_pkg::ACT_NORM, MX, 0, 0, 0, 0, 0, 0);
      add_op(vvu_pkg::ACT_NORM, 3 * ONE, -4 * ONE, 0, 0, 0, 0, 0);
      add_op(vvu_pkg::ACT_DIST, MX, MX, MX, MN, MN, MN, 0);
      add_op(vvu_pkg::ACT_DIST, 0, 0, 0, ONE, ONE, ONE, 0);
      drain();

      eps_list = '{16'hFFFF, 16'd0, 16'd300, 16'h8000, 16'd1};
      foreach (eps_list[i]) begin
         write_epsilon(eps_list[i]);
         add_op(vvu_pkg::ACT_NORM, 0, 0, 0, 0, 0, 0, 0);
         add_op(vvu_pkg::ACT_NORM, 1, 0, 0, 0, 0, 0, 0);
         add_op(vvu_pkg::ACT_NORM, 32'sd299, 0, 0, 0, 0, 0, 0);
         add_op(vvu_pkg::ACT_NORM, 32'sh0000_8000, 0, 0, 0, 0, 0, 0);
         add_op(vvu_pkg::ACT_NORM, 32'sh0000_FFFF, 0, 0, 0, 0, 0, 0);
         for (int n = 0; n < 225; n++)
            pending_ops.push_back(random_op());
         drain();
      end

      if (errors == 0 && expected_results.size() == 0)
         $display("vec3_vector_unit test passed");
      else
         $display("vec3_vector_unit test failed");
      $finish;
   end
endmodule

@@ filelist.f @@
hw/rtl/vvu_pkg.sv
hw/rtl/vvu_sqrt_cell.sv
hw/rtl/vvu_div_cell.sv
hw/rtl/vec3_vector_unit.sv
tb/tb_vec3_vector_unit.sv
